// ===== src/lsdc_pkg.sv =====
package lsdc_pkg;

  localparam int unsigned ROM_DEPTH = 199;
  localparam int unsigned FIRST_YEAR = 1901;
  localparam int unsigned IDX_W = 8;

  typedef enum logic {
    KIND_TO_SOLAR = 1'b0,
    KIND_TO_LUNAR = 1'b1
  } kind_t;

  // leap month [23:20], month sizes [19:7] (slot 1 at bit 19), festival month [6:5], day [4:0]
  localparam logic [23:0] YEAR_TABLE [ROM_DEPTH] = '{
    24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544,
    24'h46AAB9, 24'h056A4D, 24'h09AD42, 24'h24AEB6, 24'h04AE4A,
    24'h6A4DBE, 24'h0A4D52, 24'h0D2546, 24'h5D52BA, 24'h0B544E,
    24'h0D6A43, 24'h296D37, 24'h095B4B, 24'h749BC1, 24'h049754,
    24'h0A4B48, 24'h5B25BC, 24'h06A550, 24'h06D445, 24'h4ADAB8,
    24'h02B64D, 24'h095742, 24'h2497B7, 24'h04974A, 24'h664B3E,
    24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644,
    24'h393738, 24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48,
    24'h6DA53B, 24'h0B554F, 24'h056A45, 24'h4AADB9, 24'h025D4D,
    24'h092D42, 24'h2C95B6, 24'h0A954A, 24'h7B4ABD, 24'h06CA51,
    24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43, 24'h352BB8,
    24'h052B4C, 24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h6AD53C,
    24'h0AB54F, 24'h04B645, 24'h4A5739, 24'h0A574D, 24'h052642,
    24'h3E9335, 24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46,
    24'h54AEBB, 24'h04AD4F, 24'h0A4D43, 24'h4D26B7, 24'h0D254B,
    24'h8D52BF, 24'h0B5452, 24'h0B6A47, 24'h696D3C, 24'h095B50,
    24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2, 24'h06A554,
    24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h093746, 24'h5497BB,
    24'h04974F, 24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF,
    24'h05AC53, 24'h0AB647, 24'h5936BC, 24'h092E50, 24'h0C9645,
    24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49,
    24'h7AADBD, 24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E,
    24'h0B4A43, 24'h4B5537, 24'h0AD54A, 24'h955ABF, 24'h04BA53,
    24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
    24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D,
    24'h0A4E51, 24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43,
    24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53, 24'h0A4D48,
    24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
    24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51,
    24'h0AA546, 24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37,
    24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48, 24'h66A53C,
    24'h0EA54F, 24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42,
    24'h3C9735, 24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545,
    24'h55AABA, 24'h056A4E, 24'h0A6D43, 24'h452EB7, 24'h052D4B,
    24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F,
    24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6,
    24'h069349, 24'h7729BD, 24'h06AA51, 24'h0AD546, 24'h54DABA,
    24'h04B64E, 24'h0A5743, 24'h452738, 24'h0D264A, 24'h8E933E,
    24'h0D5252, 24'h0DAA47, 24'h66B53B, 24'h056D4F, 24'h04AE45,
    24'h4A4EB9, 24'h0A4D4C, 24'h0D1541, 24'h2D92B5
  };

  // stage 1 -> 2
  typedef struct packed {
    kind_t       kind;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        lp;
    logic        ok;
    logic        has_prev;
    logic        leap_yr;
    logic [23:0] word;
    logic [23:0] pword;
  } fetch_t;

  // stage 2 -> 3
  typedef struct packed {
    kind_t       kind;
    logic [11:0] year;
    logic        ok;
    logic        has_prev;
    logic        leap_yr;
    logic [23:0] word;
    logic [23:0] pword;
    logic [8:0]  num;
    logic [8:0]  psum;
    logic [5:0]  sp;
  } sum_t;

  // stage 3 -> 4
  typedef struct packed {
    kind_t       kind;
    logic [11:0] year;
    logic        ok;
    logic        leap_yr;
    logic [23:0] word;
    logic [8:0]  num;
  } norm_t;

  // stage 4 -> 5
  typedef struct packed {
    kind_t       kind;
    logic [11:0] year;
    logic        ok;
    logic [3:0]  leap_mon;
    logic [3:0]  pos;
    logic [8:0]  base;
    logic [8:0]  num;
  } pos_t;

  function automatic logic [23:0] rom_word(logic [IDX_W-1:0] idx);
    logic [23:0] w;
    w = '0;
    if (idx < IDX_W'(ROM_DEPTH)) w = YEAR_TABLE[idx];
    return w;
  endfunction

  // full gregorian rule, reduced to the centuries reachable from the table span
  function automatic logic greg_leap(logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != 12'd2100) && (y != 12'd2200) && (y != 12'd2300);
  endfunction

  function automatic logic [8:0] days_before(logic [3:0] m, logic leap);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    if (leap && m > 4'd2) d = d + 9'd1;
    return d;
  endfunction

  function automatic logic [4:0] greg_len(logic [3:0] m, logic leap);
    logic [4:0] d;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11:                      d = 5'd30;
      4'd2:                                         d = leap ? 5'd29 : 5'd28;
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12:   d = 5'd31;
      default:                                      d = 5'd0;
    endcase
    return d;
  endfunction

  // zero-based day of year of the spring festival
  function automatic logic [5:0] spring_off(logic [23:0] w);
    return 6'(w[4:0]) - 6'd1 + ((w[6:5] == 2'd2) ? 6'd31 : 6'd0);
  endfunction

  // total days in the first k month slots
  function automatic logic [8:0] prefix_days(logic [23:0] w, logic [3:0] k);
    logic [12:0] b;
    logic [12:0] mask;
    b = '0;
    for (int j = 0; j < 13; j++) b[j] = w[19-j];
    mask = (13'd1 << k) - 13'd1;
    return 9'(k) * 9'd29 + 9'($countones(b & mask));
  endfunction

endpackage

// ===== src/lsdc_fetch.sv =====
module lsdc_fetch #(
  parameter int TABLE_YEARS = 199
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic                  kind,
  input  logic [11:0]           in_year,
  input  logic [3:0]            in_month,
  input  logic [4:0]            in_day,
  input  logic                  in_leap,
  output logic                  v_o,
  output lsdc_pkg::fetch_t      s_o
);

  localparam logic [11:0] FIRST = 12'(lsdc_pkg::FIRST_YEAR);
  localparam logic [11:0] SPAN  = 12'(TABLE_YEARS);
  localparam logic [11:0] DEPTH = 12'(lsdc_pkg::ROM_DEPTH);

  logic [11:0]              idx_full;
  logic [lsdc_pkg::IDX_W-1:0] idx;
  logic [lsdc_pkg::IDX_W-1:0] pidx;
  logic                     in_table;
  logic                     leap;
  logic                     month_ok;
  logic                     day_ok;
  lsdc_pkg::fetch_t         s_next;

  always_comb begin
    idx_full = in_year - FIRST;
    in_table = (in_year >= FIRST) && (idx_full < SPAN) && (idx_full < DEPTH);
    idx      = idx_full[lsdc_pkg::IDX_W-1:0];
    pidx     = idx - {{(lsdc_pkg::IDX_W-1){1'b0}}, 1'b1};
    leap     = lsdc_pkg::greg_leap(in_year);
    month_ok = (in_month >= 4'd1) && (in_month <= 4'd12);
    if (lsdc_pkg::kind_t'(kind) == lsdc_pkg::KIND_TO_SOLAR) begin
      day_ok = (in_day >= 5'd1) && (in_day <= 5'd30);
    end else begin
      day_ok = (in_day >= 5'd1) && (in_day <= lsdc_pkg::greg_len(in_month, leap));
    end
    s_next.kind     = lsdc_pkg::kind_t'(kind);
    s_next.year     = in_year;
    s_next.month    = in_month;
    s_next.day      = in_day;
    s_next.lp       = in_leap;
    s_next.ok       = in_table && month_ok && day_ok;
    s_next.has_prev = (idx != '0);
    s_next.leap_yr  = leap;
    s_next.word     = lsdc_pkg::rom_word(idx);
    s_next.pword    = lsdc_pkg::rom_word(pidx);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_o <= s_next;
    end
  end

endmodule

// ===== src/lsdc_dayno.sv =====
module lsdc_dayno (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             v_i,
  input  lsdc_pkg::fetch_t s_i,
  output logic             v_o,
  output lsdc_pkg::norm_t  s_o
);

  logic             v2;
  lsdc_pkg::sum_t   s2;
  lsdc_pkg::sum_t   s2_next;
  lsdc_pkg::norm_t  s3_next;

  logic [3:0]  lmon;
  logic        extra;
  logic [3:0]  k;
  logic [3:0]  plast;
  logic [5:0]  sp;
  logic [8:0]  ylen;
  logic [11:0] ynext;
  logic [9:0]  wrap;

  // stage 2: day number of the date within its own year
  always_comb begin
    lmon  = s_i.word[23:20];
    extra = (lmon != 4'd0) && ((s_i.month > lmon) || (s_i.month == lmon && s_i.lp));
    k     = s_i.month - 4'd1 + {3'b000, extra};
    plast = (s_i.pword[23:20] != 4'd0) ? 4'd13 : 4'd12;
    sp    = lsdc_pkg::spring_off(s_i.word);

    s2_next.kind     = s_i.kind;
    s2_next.year     = s_i.year;
    s2_next.ok       = s_i.ok;
    s2_next.has_prev = s_i.has_prev;
    s2_next.leap_yr  = s_i.leap_yr;
    s2_next.word     = s_i.word;
    s2_next.pword    = s_i.pword;
    s2_next.sp       = sp;
    s2_next.psum     = lsdc_pkg::prefix_days(s_i.pword, plast);
    if (s_i.kind == lsdc_pkg::KIND_TO_SOLAR) begin
      // one-based day of the gregorian year
      s2_next.num = 9'(sp) + 9'(s_i.day) + lsdc_pkg::prefix_days(s_i.word, k);
    end else begin
      s2_next.num = 9'(s_i.day) - 9'd1 + lsdc_pkg::days_before(s_i.month, s_i.leap_yr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
    end
  end

  // stage 3: fold into the right year
  always_comb begin
    ylen  = s2.leap_yr ? 9'd366 : 9'd365;
    ynext = s2.year + 12'd1;
    wrap  = 10'(s2.num) + 10'(s2.psum) - 10'(s2.sp);

    s3_next.kind    = s2.kind;
    s3_next.year    = s2.year;
    s3_next.ok      = s2.ok;
    s3_next.word    = s2.word;
    s3_next.num     = s2.num;
    s3_next.leap_yr = s2.leap_yr;
    if (s2.kind == lsdc_pkg::KIND_TO_SOLAR) begin
      if (s2.num > ylen) begin
        s3_next.year    = ynext;
        s3_next.num     = s2.num - ylen;
        s3_next.leap_yr = lsdc_pkg::greg_leap(ynext);
      end
    end else begin
      if (s2.num >= 9'(s2.sp)) begin
        s3_next.num = s2.num - 9'(s2.sp);
      end else begin
        // before the festival: offset into the previous lunar year
        s3_next.num  = wrap[8:0];
        s3_next.word = s2.pword;
        s3_next.year = s2.year - 12'd1;
        s3_next.ok   = s2.ok && s2.has_prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_o <= 1'b0;
    end else if (en) begin
      v_o <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_o <= s3_next;
    end
  end

endmodule

// ===== src/lsdc_locate.sv =====
module lsdc_locate (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic            v_i,
  input  lsdc_pkg::norm_t s_i,
  output logic            out_valid,
  output logic [11:0]     out_year,
  output logic [3:0]      out_month,
  output logic [4:0]      out_day,
  output logic            out_leap,
  output logic            out_error
);

  logic            v4;
  lsdc_pkg::pos_t  s4;
  lsdc_pkg::pos_t  s4_next;

  logic [10:0] hit_greg;
  logic [11:0] hit_slot;
  logic [8:0]  cum [13];
  logic [3:0]  last;
  logic [3:0]  gcnt;
  logic [3:0]  scnt;

  logic [11:0] year_next;
  logic [3:0]  month_next;
  logic [4:0]  day_next;
  logic        leap_next;
  logic [8:0]  diff;

  // stage 4: month search by parallel compares against running totals
  always_comb begin
    last = (s_i.word[23:20] != 4'd0) ? 4'd13 : 4'd12;
    for (int j = 0; j < 13; j++) begin
      cum[j] = lsdc_pkg::prefix_days(s_i.word, 4'(j));
    end
    for (int j = 0; j < 11; j++) begin
      hit_greg[j] = lsdc_pkg::days_before(4'(j + 2), s_i.leap_yr) < s_i.num;
    end
    for (int j = 0; j < 12; j++) begin
      hit_slot[j] = (4'(j + 1) < last) && (cum[j+1] <= s_i.num);
    end
    gcnt = 4'($countones(hit_greg));
    scnt = 4'($countones(hit_slot));

    s4_next.kind     = s_i.kind;
    s4_next.year     = s_i.year;
    s4_next.ok       = s_i.ok;
    s4_next.leap_mon = s_i.word[23:20];
    s4_next.num      = s_i.num;
    if (s_i.kind == lsdc_pkg::KIND_TO_SOLAR) begin
      s4_next.pos  = gcnt + 4'd1;
      s4_next.base = lsdc_pkg::days_before(gcnt + 4'd1, s_i.leap_yr);
    end else begin
      s4_next.pos  = scnt + 4'd1;
      s4_next.base = cum[scnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4 <= s4_next;
    end
  end

  // stage 5: day of month, slot to lunar month, error zeroing
  always_comb begin
    diff       = s4.num - s4.base;
    year_next  = s4.year;
    leap_next  = 1'b0;
    month_next = s4.pos;
    if (s4.kind == lsdc_pkg::KIND_TO_SOLAR) begin
      day_next = diff[4:0];
    end else begin
      day_next = diff[4:0] + 5'd1;
      if (s4.leap_mon == 4'd0 || s4.pos <= s4.leap_mon) begin
        month_next = s4.pos;
      end else if (s4.pos == s4.leap_mon + 4'd1) begin
        month_next = s4.leap_mon;
        leap_next  = 1'b1;
      end else begin
        month_next = s4.pos - 4'd1;
      end
    end
    if (!s4.ok) begin
      year_next  = '0;
      month_next = '0;
      day_next   = '0;
      leap_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_year  <= year_next;
      out_month <= month_next;
      out_day   <= day_next;
      out_leap  <= leap_next;
      out_error <= !s4.ok;
    end
  end

endmodule

// ===== src/lunar_solar_date_converter.sv =====
// channel | handshake            | payload
// in      | in_valid / in_ready  | kind, in_year, in_month, in_day, in_leap
// out     | out_valid / out_ready| out_year, out_month, out_day, out_leap, out_error
//
// five register stages: fetch, day number, year fold, month search, output register
// one transaction per cycle unless the output stalls
// a stalled output holds every stage in place, so in_ready is high when out_ready is high or out_valid is low
// reset clears the valid bits only; the year table is a constant rom
module lunar_solar_date_converter #(
  parameter int TABLE_YEARS = 199
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        kind,
  input  logic [11:0] in_year,
  input  logic [3:0]  in_month,
  input  logic [4:0]  in_day,
  input  logic        in_leap,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day,
  output logic        out_leap,
  output logic        out_error
);

  logic             en;
  logic             v1;
  logic             v3;
  lsdc_pkg::fetch_t s1;
  lsdc_pkg::norm_t  s3;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  lsdc_fetch #(
    .TABLE_YEARS(TABLE_YEARS)
  ) u_fetch (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (in_valid),
    .kind     (kind),
    .in_year  (in_year),
    .in_month (in_month),
    .in_day   (in_day),
    .in_leap  (in_leap),
    .v_o      (v1),
    .s_o      (s1)
  );

  lsdc_dayno u_dayno (
    .clk (clk),
    .rst (rst),
    .en  (en),
    .v_i (v1),
    .s_i (s1),
    .v_o (v3),
    .s_o (s3)
  );

  lsdc_locate u_locate (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .v_i       (v3),
    .s_i       (s3),
    .out_valid (out_valid),
    .out_year  (out_year),
    .out_month (out_month),
    .out_day   (out_day),
    .out_leap  (out_leap),
    .out_error (out_error)
  );

endmodule

// ===== src/lsdc_checker.sv =====
module lsdc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day,
  input logic        out_leap,
  input logic        out_error
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // an empty output stage never blocks the input side
  a_ready_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_year) && $stable(out_month)
      && $stable(out_day) && $stable(out_leap) && $stable(out_error))
    else $error("stalled transaction changed");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_error |-> out_year == 12'd0 && out_month == 4'd0
      && out_day == 5'd0 && !out_leap)
    else $error("error transaction with nonzero date");

  a_date_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_error |-> out_month != 4'd0 && out_month <= 4'd12 && out_day != 5'd0)
    else $error("converted date out of range");

endmodule

bind lunar_solar_date_converter lsdc_checker u_lsdc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_year  (out_year),
  .out_month (out_month),
  .out_day   (out_day),
  .out_leap  (out_leap),
  .out_error (out_error)
);

// ===== dv/lunar_solar_date_converter_test.sv =====
module lunar_solar_date_converter_test;

  localparam int unsigned FIRST_CAL_YEAR = 1901;
  localparam int unsigned CAL_YEARS = 199;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned PHASE_ITEMS = 240;

  // leap month [23:20], month sizes [19:7], festival month [6:5] and day [4:0]
  localparam logic [23:0] LUNAR_YEARS [CAL_YEARS] = '{
    24'h04AE53, 24'h0A5748, 24'h5526BD, 24'h0D2650, 24'h0D9544,
    24'h46AAB9, 24'h056A4D, 24'h09AD42, 24'h24AEB6, 24'h04AE4A,
    24'h6A4DBE, 24'h0A4D52, 24'h0D2546, 24'h5D52BA, 24'h0B544E,
    24'h0D6A43, 24'h296D37, 24'h095B4B, 24'h749BC1, 24'h049754,
    24'h0A4B48, 24'h5B25BC, 24'h06A550, 24'h06D445, 24'h4ADAB8,
    24'h02B64D, 24'h095742, 24'h2497B7, 24'h04974A, 24'h664B3E,
    24'h0D4A51, 24'h0EA546, 24'h56D4BA, 24'h05AD4E, 24'h02B644,
    24'h393738, 24'h092E4B, 24'h7C96BF, 24'h0C9553, 24'h0D4A48,
    24'h6DA53B, 24'h0B554F, 24'h056A45, 24'h4AADB9, 24'h025D4D,
    24'h092D42, 24'h2C95B6, 24'h0A954A, 24'h7B4ABD, 24'h06CA51,
    24'h0B5546, 24'h555ABB, 24'h04DA4E, 24'h0A5B43, 24'h352BB8,
    24'h052B4C, 24'h8A953F, 24'h0E9552, 24'h06AA48, 24'h6AD53C,
    24'h0AB54F, 24'h04B645, 24'h4A5739, 24'h0A574D, 24'h052642,
    24'h3E9335, 24'h0D9549, 24'h75AABE, 24'h056A51, 24'h096D46,
    24'h54AEBB, 24'h04AD4F, 24'h0A4D43, 24'h4D26B7, 24'h0D254B,
    24'h8D52BF, 24'h0B5452, 24'h0B6A47, 24'h696D3C, 24'h095B50,
    24'h049B45, 24'h4A4BB9, 24'h0A4B4D, 24'hAB25C2, 24'h06A554,
    24'h06D449, 24'h6ADA3D, 24'h0AB651, 24'h093746, 24'h5497BB,
    24'h04974F, 24'h064B44, 24'h36A537, 24'h0EA54A, 24'h86B2BF,
    24'h05AC53, 24'h0AB647, 24'h5936BC, 24'h092E50, 24'h0C9645,
    24'h4D4AB8, 24'h0D4A4C, 24'h0DA541, 24'h25AAB6, 24'h056A49,
    24'h7AADBD, 24'h025D52, 24'h092D47, 24'h5C95BA, 24'h0A954E,
    24'h0B4A43, 24'h4B5537, 24'h0AD54A, 24'h955ABF, 24'h04BA53,
    24'h0A5B48, 24'h652BBC, 24'h052B50, 24'h0A9345, 24'h474AB9,
    24'h06AA4C, 24'h0AD541, 24'h24DAB6, 24'h04B64A, 24'h69573D,
    24'h0A4E51, 24'h0D2646, 24'h5E933A, 24'h0D534D, 24'h05AA43,
    24'h36B537, 24'h096D4B, 24'hB4AEBF, 24'h04AD53, 24'h0A4D48,
    24'h6D25BC, 24'h0D254F, 24'h0D5244, 24'h5DAA38, 24'h0B5A4C,
    24'h056D41, 24'h24ADB6, 24'h049B4A, 24'h7A4BBE, 24'h0A4B51,
    24'h0AA546, 24'h5B52BA, 24'h06D24E, 24'h0ADA42, 24'h355B37,
    24'h09374B, 24'h8497C1, 24'h049753, 24'h064B48, 24'h66A53C,
    24'h0EA54F, 24'h06B244, 24'h4AB638, 24'h0AAE4C, 24'h092E42,
    24'h3C9735, 24'h0C9649, 24'h7D4ABD, 24'h0D4A51, 24'h0DA545,
    24'h55AABA, 24'h056A4E, 24'h0A6D43, 24'h452EB7, 24'h052D4B,
    24'h8A95BF, 24'h0A9553, 24'h0B4A47, 24'h6B553B, 24'h0AD54F,
    24'h055A45, 24'h4A5D38, 24'h0A5B4C, 24'h052B42, 24'h3A93B6,
    24'h069349, 24'h7729BD, 24'h06AA51, 24'h0AD546, 24'h54DABA,
    24'h04B64E, 24'h0A5743, 24'h452738, 24'h0D264A, 24'h8E933E,
    24'h0D5252, 24'h0DAA47, 24'h66B53B, 24'h056D4F, 24'h04AE45,
    24'h4A4EB9, 24'h0A4D4C, 24'h0D1541, 24'h2D92B5
  };

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        leap;
    logic        err;
  } converted_date_t;

  class conversion_scoreboard;
    converted_date_t expected_dates[$];
    int unsigned failures;

    function new();
      failures = 0;
    endfunction

    function bit greg_leap_year(int unsigned y);
      return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
    endfunction

    function int unsigned greg_days(int unsigned y, int unsigned m);
      int unsigned d;
      case (m)
        4, 6, 9, 11: d = 30;
        2:           d = greg_leap_year(y) ? 29 : 28;
        default:     d = 31;
      endcase
      return d;
    endfunction

    function bit lookup(int unsigned y, output logic [23:0] w);
      w = '0;
      if (y < FIRST_CAL_YEAR || y - FIRST_CAL_YEAR >= CAL_YEARS) return 1'b0;
      w = LUNAR_YEARS[y - FIRST_CAL_YEAR];
      return 1'b1;
    endfunction

    // slot 1..13 maps to bit 19..7, set means a 30-day month
    function int unsigned moon_len(logic [23:0] w, int unsigned s);
      if (s < 1 || s > 13) return 29;
      return w[20 - s] ? 30 : 29;
    endfunction

    function int unsigned festival_doy(logic [23:0] w);
      return int'(w[4:0]) - 1 + ((w[6:5] == 2'd2) ? 31 : 0);
    endfunction

    // the leap month occupies the slot right after its ordinary month
    function void slot_month(logic [23:0] w, int unsigned s,
                             output int unsigned m, output bit lp);
      int unsigned x;
      x = 32'(w[23:20]);
      lp = 1'b0;
      if (x == 0 || s <= x) begin
        m = s;
      end else if (s == x + 1) begin
        m = x;
        lp = 1'b1;
      end else begin
        m = s - 1;
      end
    endfunction

    function converted_date_t convert(lsdc_pkg::kind_t k, int unsigned y, int unsigned m,
                                      int unsigned d, bit lp);
      converted_date_t r;
      logic [23:0] w, pw;
      bit ok, ol;
      int unsigned i, x, n, ylen, doy, rem, s, last, sp, om;
      r = '0;
      ol = 1'b0;
      om = 0;
      ok = lookup(y, w);
      if (ok && k == lsdc_pkg::KIND_TO_SOLAR) begin
        if (m < 1 || m > 12 || d < 1 || d > 30) begin
          ok = 1'b0;
        end else begin
          x = 32'(w[23:20]);
          n = festival_doy(w) + d;
          for (i = 1; i < m; i++) n += moon_len(w, i);
          if (x != 0 && (m > x || (m == x && lp))) n += moon_len(w, m);
          ylen = greg_leap_year(y) ? 366 : 365;
          if (n > ylen) begin
            y++;
            n -= ylen;
          end
          om = 1;
          while (om < 12 && n > greg_days(y, om)) begin
            n -= greg_days(y, om);
            om++;
          end
          r.year = 12'(y);
          r.day = 5'(n);
        end
      end else if (ok) begin
        if (m < 1 || m > 12 || d < 1 || d > greg_days(y, m)) begin
          ok = 1'b0;
        end else begin
          doy = d - 1;
          for (i = 1; i < m; i++) doy += greg_days(y, i);
          sp = festival_doy(w);
          if (doy >= sp) begin
            last = (w[23:20] != 0) ? 13 : 12;
            rem = doy - sp;
            s = 1;
            while (s < last && rem >= moon_len(w, s)) begin
              rem -= moon_len(w, s);
              s++;
            end
            slot_month(w, s, om, ol);
            r.year = 12'(y);
            r.day = 5'(rem + 1);
          end else if (!lookup(y - 1, pw)) begin
            // before the first festival the lunar year is off the table
            ok = 1'b0;
          end else begin
            s = (pw[23:20] != 0) ? 13 : 12;
            rem = sp - doy;
            while (s > 1 && rem > moon_len(pw, s)) begin
              rem -= moon_len(pw, s);
              s--;
            end
            slot_month(pw, s, om, ol);
            r.year = 12'(y - 1);
            r.day = 5'(moon_len(pw, s) - rem + 1);
          end
        end
      end
      r.month = 4'(om);
      r.leap = ol;
      if (!ok) r = '0;
      r.err = !ok;
      return r;
    endfunction

    function void note_request(lsdc_pkg::kind_t k, int unsigned y, int unsigned m,
                               int unsigned d, bit lp);
      expected_dates.push_back(convert(k, y, m, d, lp));
    endfunction

    function void check_result(converted_date_t got);
      converted_date_t want;
      if (expected_dates.size() == 0) begin
        failures++;
        $error("unexpected result: year %0d month %0d day %0d leap %0d error %0d",
               got.year, got.month, got.day, got.leap, got.err);
        return;
      end
      want = expected_dates.pop_front();
      if (got.year !== want.year) begin
        failures++;
        $error("out_year: expected %0d, got %0d", want.year, got.year);
      end
      if (got.month !== want.month) begin
        failures++;
        $error("out_month: expected %0d, got %0d", want.month, got.month);
      end
      if (got.day !== want.day) begin
        failures++;
        $error("out_day: expected %0d, got %0d", want.day, got.day);
      end
      if (got.leap !== want.leap) begin
        failures++;
        $error("out_leap: expected %0d, got %0d", want.leap, got.leap);
      end
      if (got.err !== want.err) begin
        failures++;
        $error("out_error: expected %0d, got %0d", want.err, got.err);
      end
    endfunction

    function int unsigned outstanding();
      return expected_dates.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        kind;
  logic [11:0] in_year;
  logic [3:0]  in_month;
  logic [4:0]  in_day;
  logic        in_leap;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day;
  logic        out_leap;
  logic        out_error;

  conversion_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit long_hold = 1'b0;
  bit hold_done = 1'b0;
  int unsigned quiet_cycles = 0;

  lunar_solar_date_converter DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .in_year   (in_year),
    .in_month  (in_month),
    .in_day    (in_day),
    .in_leap   (in_leap),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_year  (out_year),
    .out_month (out_month),
    .out_day   (out_day),
    .out_leap  (out_leap),
    .out_error (out_error)
  );

  always #1 clk = ~clk;

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result(converted_date_t'{out_year, out_month, out_day, out_leap, out_error});
    if (!rst && in_valid && in_ready)
      sb.note_request(lsdc_pkg::kind_t'(kind), 32'(in_year), 32'(in_month),
                      32'(in_day), in_leap);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("[lunar_solar_date_converter] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input lsdc_pkg::kind_t k, input int unsigned y,
                              input int unsigned m, input int unsigned d, input bit lp);
    @(negedge clk);
    in_valid <= 1'b1;
    kind <= k;
    in_year <= 12'(y);
    in_month <= 4'(m);
    in_day <= 5'(d);
    in_leap <= lp;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic send_random_request();
    int unsigned y, m, d, pick;
    lsdc_pkg::kind_t k;
    bit lp;
    pick = $urandom_range(99);
    k = lsdc_pkg::kind_t'($urandom_range(1));
    lp = 1'($urandom_range(1));
    if (pick < 8) begin
      y = $urandom_range(4095);
      m = $urandom_range(15);
      d = $urandom_range(31);
    end else if (pick < 15) begin
      y = $urandom_range(2099, 1901);
      m = $urandom_range(15);
      d = $urandom_range(31);
    end else begin
      if (pick < 28) begin
        // the ends of the table: early dates of the first years, late ones of the last
        if (k == lsdc_pkg::KIND_TO_LUNAR) begin
          y = $urandom_range(1902, 1901);
          m = $urandom_range(2, 1);
        end else begin
          y = $urandom_range(2099, 2098);
          m = $urandom_range(12, 10);
        end
      end else begin
        y = $urandom_range(2099, 1901);
        m = $urandom_range(12, 1);
      end
      if (k == lsdc_pkg::KIND_TO_LUNAR) begin
        d = $urandom_range(sb.greg_days(y, m), 1);
      end else begin
        d = $urandom_range(30, 1);
        if (lp && LUNAR_YEARS[y - FIRST_CAL_YEAR][23:20] != 0 && $urandom_range(1))
          m = 32'(LUNAR_YEARS[y - FIRST_CAL_YEAR][23:20]);
      end
    end
    send_request(k, y, m, d, lp);
  endtask

  // sender pauses until every pending conversion has come back
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall,
                           input int unsigned count);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    repeat (count) send_random_request();
    wait_idle();
  endtask

  task automatic directed_requests();
    send_request(lsdc_pkg::KIND_TO_SOLAR, 1901, 1, 1, 1'b0);
    send_request(lsdc_pkg::KIND_TO_SOLAR, 2099, 12, 30, 1'b0);
    send_request(lsdc_pkg::KIND_TO_SOLAR, 1903, 5, 15, 1'b1);
    send_request(lsdc_pkg::KIND_TO_SOLAR, 1903, 5, 15, 1'b0);
    send_request(lsdc_pkg::KIND_TO_SOLAR, 1903, 4, 10, 1'b1);
    send_request(lsdc_pkg::KIND_TO_SOLAR, 1901, 1, 30, 1'b0);
    send_request(lsdc_pkg::KIND_TO_SOLAR, 1901, 0, 5, 1'b0);
    send_request(lsdc_pkg::KIND_TO_SOLAR, 1950, 13, 5, 1'b0);
    send_request(lsdc_pkg::KIND_TO_SOLAR, 1950, 6, 0, 1'b0);
    send_request(lsdc_pkg::KIND_TO_SOLAR, 1950, 6, 31, 1'b1);
    send_request(lsdc_pkg::KIND_TO_SOLAR, 1900, 1, 1, 1'b0);
    send_request(lsdc_pkg::KIND_TO_SOLAR, 2100, 1, 1, 1'b0);
    send_request(lsdc_pkg::KIND_TO_SOLAR, 4095, 15, 31, 1'b1);
    send_request(lsdc_pkg::KIND_TO_LUNAR, 1901, 1, 1, 1'b0);
    send_request(lsdc_pkg::KIND_TO_LUNAR, 1901, 2, 18, 1'b0);
    send_request(lsdc_pkg::KIND_TO_LUNAR, 1901, 2, 19, 1'b1);
    send_request(lsdc_pkg::KIND_TO_LUNAR, 2099, 12, 31, 1'b0);
    send_request(lsdc_pkg::KIND_TO_LUNAR, 2099, 1, 1, 1'b0);
    send_request(lsdc_pkg::KIND_TO_LUNAR, 2000, 2, 29, 1'b0);
    send_request(lsdc_pkg::KIND_TO_LUNAR, 2001, 2, 29, 1'b0);
    send_request(lsdc_pkg::KIND_TO_LUNAR, 2020, 6, 1, 1'b0);
    send_request(lsdc_pkg::KIND_TO_LUNAR, 2023, 4, 1, 1'b1);
    send_request(lsdc_pkg::KIND_TO_LUNAR, 1950, 13, 1, 1'b0);
    send_request(lsdc_pkg::KIND_TO_LUNAR, 1950, 4, 31, 1'b0);
    send_request(lsdc_pkg::KIND_TO_LUNAR, 0, 0, 0, 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = lsdc_pkg::KIND_TO_SOLAR;
    in_year = '0;
    in_month = '0;
    in_day = '0;
    in_leap = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    directed_requests();
    wait_idle();
    run_phase(0, 0, PHASE_ITEMS);
    run_phase(52, 0, PHASE_ITEMS);

    // long receiver hold-off while the sender keeps pushing: the pipe fills and stalls
    send_idle_pct = 0;
    stall_pct = 0;
    long_hold = 1'b1;
    repeat (40) send_random_request();
    wait_idle();
    long_hold = 1'b0;

    run_phase(0, 52, PHASE_ITEMS);
    run_phase(19, 19, PHASE_ITEMS);

    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("[lunar_solar_date_converter] OK");
    end else begin
      $display("[lunar_solar_date_converter] ERROR");
    end
    $finish;
  end

endmodule
